// File: sv/swat_pkg.sv
// Shared types, constants and slot-index tables for the sliding window ARQ tracker.
package swat_pkg;

	localparam int SLOTS    = 16;
	localparam int SEQ_W    = 12;
	localparam int CRED_W   = 5;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int EFF_CAP  = (SLOTS < 31) ? SLOTS : 31;

	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [SEQ_W-1:0]  seq_t;
	typedef logic [CRED_W-1:0] cred_t;

	typedef enum logic [1:0] {
		MODE_SEND     = 2'd0,
		MODE_DATA     = 2'd1,
		MODE_FEEDBACK = 2'd2,
		MODE_UNUSED   = 2'd3
	} in_mode_t;

	typedef enum logic [1:0] {
		SVC_TRANSPARENT = 2'd0,
		SVC_SEQUENCED   = 2'd1,
		SVC_FLOW        = 2'd2,
		SVC_FLOW_ARQ    = 2'd3
	} svc_mode_t;

	typedef enum logic [2:0] {
		KIND_SEND = 3'd0,
		KIND_DATA = 3'd1,
		KIND_ACK  = 3'd2,
		KIND_NACK = 3'd3,
		KIND_NONE = 3'd4
	} ev_kind_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_OVERWRITE = 3'd2,
		STAT_DROPPED   = 3'd3,
		STAT_NACK      = 3'd4
	} status_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_CLEAR = 1'b1
	} back_state_t;

	typedef struct packed {
		ev_kind_t kind;
		seq_t     seq_num;
		logic     complete_sdu;
	} ev_item_t;

	typedef slot_t lo_tab_t [256];
	typedef slot_t hi_tab_t [16];

	function automatic lo_tab_t build_lo_tab();
		lo_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SLOT_W'(i % SLOTS);
		end
		return t;
	endfunction

	function automatic hi_tab_t build_hi_tab();
		hi_tab_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = SLOT_W'((i * 256) % SLOTS);
		end
		return t;
	endfunction

	localparam lo_tab_t LO_MOD = build_lo_tab();
	localparam hi_tab_t HI_MOD = build_hi_tab();

	function automatic slot_t seq_slot(input seq_t s);
		logic [SLOT_W:0] sum;
		sum = {1'b0, HI_MOD[s[11:8]]} + {1'b0, LO_MOD[s[7:0]]};
		if (sum >= (SLOT_W+1)'(SLOTS)) begin
			sum = sum - (SLOT_W+1)'(SLOTS);
		end
		return sum[SLOT_W-1:0];
	endfunction

	function automatic cred_t eff_window(input cred_t ws);
		cred_t w;
		w = ws;
		if (int'(ws) > EFF_CAP) begin
			w = CRED_W'(EFF_CAP);
		end
		return w;
	endfunction

endpackage

// File: sv/swat_front.sv
// Front end: accepts input items, classifies them and buffers them in a short queue.
module swat_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [swat_pkg::IN_TDATA_W-1:0]     s_tdata,  // seq_num[11:0], complete_sdu, zero pad
	input  logic [swat_pkg::IN_TUSER_W-1:0]     s_tuser,  // mode[1:0], is_ack
	output logic                                q_valid,
	input  logic                                q_ready,
	output swat_pkg::ev_item_t                  q_item
);

	swat_pkg::ev_item_t item_in;
	swat_pkg::ev_item_t queue_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;
	logic               pop;

	always_comb begin
		item_in.seq_num      = s_tdata[11:0];
		item_in.complete_sdu = s_tdata[12];
		unique case (swat_pkg::in_mode_t'(s_tuser[1:0]))
			swat_pkg::MODE_SEND:     item_in.kind = swat_pkg::KIND_SEND;
			swat_pkg::MODE_DATA:     item_in.kind = swat_pkg::KIND_DATA;
			swat_pkg::MODE_FEEDBACK: item_in.kind = s_tuser[2] ? swat_pkg::KIND_ACK
			                                                   : swat_pkg::KIND_NACK;
			default:                 item_in.kind = swat_pkg::KIND_NONE;
		endcase
	end

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = queue_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/swat_back.sv
// Back end: executes queued events, walks the slot marks on an ACK and holds the result.
module swat_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swat_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swat_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  swat_pkg::ev_item_t                   q_item,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [swat_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	swat_pkg::svc_mode_t          service_q, service_d;
	swat_pkg::cred_t              wsize_q, wsize_d;
	swat_pkg::seq_t               next_tx_q, next_tx_d;
	swat_pkg::seq_t               wstart_q, wstart_d;
	swat_pkg::seq_t               expected_q, expected_d;
	swat_pkg::cred_t              credits_q, credits_d;
	logic [swat_pkg::SLOTS-1:0]   marks_q, marks_d;
	swat_pkg::back_state_t        st_q, st_d;
	logic [swat_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	swat_pkg::seq_t               wseq_q, wseq_d;
	swat_pkg::seq_t               pend_start_q, pend_start_d;
	logic                         out_valid_q, out_valid_d;
	swat_pkg::status_t            status_q, status_d;
	swat_pkg::seq_t               seq_out_q, seq_out_d;
	logic                         deliver_q, deliver_d;
	logic                         send_ack_q, send_ack_d;

	swat_pkg::cred_t              eff;
	logic                         fc;
	swat_pkg::slot_t              slot_idx;
	swat_pkg::seq_t               new_start;
	swat_pkg::seq_t               span;
	logic [swat_pkg::CNT_W-1:0]   span_c;

	assign eff       = swat_pkg::eff_window(wsize_q);
	assign fc        = (service_q == swat_pkg::SVC_FLOW) || (service_q == swat_pkg::SVC_FLOW_ARQ);
	assign slot_idx  = (st_q == swat_pkg::ST_CLEAR) ? swat_pkg::seq_slot(wseq_q)
	                                                : swat_pkg::seq_slot(next_tx_q);
	assign new_start = q_item.seq_num + swat_pkg::SEQ_W'(1);
	assign span      = new_start - wstart_q;
	assign span_c    = (span > swat_pkg::SEQ_W'(swat_pkg::SLOTS))
	                   ? swat_pkg::CNT_W'(swat_pkg::SLOTS) : span[swat_pkg::CNT_W-1:0];

	always_comb begin
		service_d    = service_q;
		wsize_d      = wsize_q;
		next_tx_d    = next_tx_q;
		wstart_d     = wstart_q;
		expected_d   = expected_q;
		credits_d    = credits_q;
		marks_d      = marks_q;
		st_d         = st_q;
		cnt_d        = cnt_q;
		wseq_d       = wseq_q;
		pend_start_d = pend_start_q;
		out_valid_d  = out_valid_q && !m_tready;
		status_d     = status_q;
		seq_out_d    = seq_out_q;
		deliver_d    = deliver_q;
		send_ack_d   = send_ack_q;
		q_ready      = 1'b0;

		unique case (st_q)
			swat_pkg::ST_IDLE: begin
				if (q_valid && (!out_valid_q || m_tready)) begin
					q_ready     = 1'b1;
					status_d    = swat_pkg::STAT_OK;
					seq_out_d   = '0;
					deliver_d   = 1'b0;
					send_ack_d  = 1'b0;
					out_valid_d = 1'b1;
					unique case (q_item.kind)
						swat_pkg::KIND_SEND: begin
							unique case (service_q)
								swat_pkg::SVC_SEQUENCED: begin
									seq_out_d = next_tx_q;
									next_tx_d = next_tx_q + swat_pkg::SEQ_W'(1);
								end
								swat_pkg::SVC_FLOW, swat_pkg::SVC_FLOW_ARQ: begin
									if (credits_q == '0) begin
										status_d = swat_pkg::STAT_FULL;
									end else begin
										credits_d = credits_q - swat_pkg::CRED_W'(1);
										if (marks_q[slot_idx]) begin
											status_d = swat_pkg::STAT_OVERWRITE;
										end
										marks_d[slot_idx] = 1'b1;
										seq_out_d = next_tx_q;
										next_tx_d = next_tx_q + swat_pkg::SEQ_W'(1);
									end
								end
								default: begin
								end
							endcase
						end
						swat_pkg::KIND_DATA: begin
							if (q_item.complete_sdu && (q_item.seq_num == expected_q)) begin
								expected_d = new_start;
								deliver_d  = 1'b1;
								if (fc) begin
									send_ack_d = 1'b1;
									seq_out_d  = q_item.seq_num;
								end
							end else begin
								status_d = swat_pkg::STAT_DROPPED;
							end
						end
						swat_pkg::KIND_ACK: begin
							if (span == '0) begin
								wstart_d = new_start;
							end else begin
								out_valid_d  = 1'b0;
								st_d         = swat_pkg::ST_CLEAR;
								cnt_d        = span_c;
								wseq_d       = wstart_q;
								pend_start_d = new_start;
							end
						end
						swat_pkg::KIND_NACK: begin
							status_d = swat_pkg::STAT_NACK;
						end
						default: begin
						end
					endcase
				end
			end
			swat_pkg::ST_CLEAR: begin
				if (marks_q[slot_idx]) begin
					marks_d[slot_idx] = 1'b0;
					if (credits_q < eff) begin
						credits_d = credits_q + swat_pkg::CRED_W'(1);
					end
				end
				cnt_d  = cnt_q - swat_pkg::CNT_W'(1);
				wseq_d = wseq_q + swat_pkg::SEQ_W'(1);
				if (cnt_q == swat_pkg::CNT_W'(1)) begin
					st_d        = swat_pkg::ST_IDLE;
					wstart_d    = pend_start_q;
					out_valid_d = 1'b1;
				end
			end
			default: begin
				st_d = swat_pkg::ST_IDLE;
			end
		endcase

		if (cfg_we) begin
			unique case (cfg_index)
				swat_pkg::CFG_SERVICE_MODE: begin
					service_d = swat_pkg::svc_mode_t'(cfg_data[1:0]);
				end
				swat_pkg::CFG_WINDOW_SIZE: begin
					wsize_d   = cfg_data;
					credits_d = swat_pkg::eff_window(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_q   <= swat_pkg::SVC_TRANSPARENT;
			wsize_q     <= '0;
			next_tx_q   <= '0;
			wstart_q    <= '0;
			expected_q  <= '0;
			credits_q   <= '0;
			marks_q     <= '0;
			st_q        <= swat_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			service_q   <= service_d;
			wsize_q     <= wsize_d;
			next_tx_q   <= next_tx_d;
			wstart_q    <= wstart_d;
			expected_q  <= expected_d;
			credits_q   <= credits_d;
			marks_q     <= marks_d;
			st_q        <= st_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		wseq_q       <= wseq_d;
		pend_start_q <= pend_start_d;
		status_q     <= status_d;
		seq_out_q    <= seq_out_d;
		deliver_q    <= deliver_d;
		send_ack_q   <= send_ack_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, wstart_q, credits_q, send_ack_q, deliver_q, seq_out_q, status_q};

	a_credits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= eff)
		else $error("credits above effective window");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == swat_pkg::ST_CLEAR) |-> (!out_valid_q && (cnt_q != '0)))
		else $error("slot walk with pending result or empty count");

	a_clear_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == swat_pkg::ST_CLEAR) && (cnt_q == swat_pkg::CNT_W'(1)))
		|=> (out_valid_q && (st_q == swat_pkg::ST_IDLE)))
		else $error("slot walk did not produce a result");

endmodule

// File: sv/sliding_window_arq_tracker_unit.sv
// Top level of the sliding window ARQ tracker: front end, event queue and back end.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: seq_num, complete_sdu; tuser: mode, is_ack
// m_*       out  m_tvalid/m_tready  tdata: status, seq_out, deliver, send_ack,
//                                          credits_left, window_base
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// Send, data, NACK and unused events each give a registered result after leaving the queue.
// An ACK that moves the window first walks the slots it covers, at most 16, in the slot-clear loop.
// The two-entry queue keeps accepting, until it is full, while a result waits on m_tready.
// arst_n clears all slot marks, counters and the queue at once.
module sliding_window_arq_tracker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swat_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swat_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [swat_pkg::IN_TDATA_W-1:0]      s_tdata,  // seq_num[11:0], complete_sdu, zero pad
	input  logic [swat_pkg::IN_TUSER_W-1:0]      s_tuser,  // mode[1:0], is_ack
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [swat_pkg::OUT_TDATA_W-1:0]     m_tdata   // status[2:0], seq_out[11:0], deliver,
	                                                       // send_ack, credits_left[4:0],
	                                                       // window_base[11:0], zero pad
);

	logic               q_valid;
	logic               q_ready;
	swat_pkg::ev_item_t q_item;

	swat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	swat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the sliding window ARQ tracker unit.
`timescale 1ns / 100ps

module tb_top;
	import swat_pkg::*;

	localparam int          SEQ_MOD      = 1 << SEQ_W;
	localparam int          PHASE_ITEMS  = 88;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          SETTLE       = 24;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef struct packed {
		status_t status;
		seq_t    seq_out;
		logic    deliver;
		logic    send_ack;
		cred_t   credits;
		seq_t    base;
	} arq_result_t;

	class window_checker;
		svc_mode_t         svc;
		cred_t             wsize;
		cred_t             credits;
		seq_t              next_tx;
		seq_t              win_start;
		seq_t              exp_rx;
		logic [SLOTS-1:0]  marks;
		arq_result_t       results_due[$];
		int                mismatches;
		int                checked;

		function new();
			svc        = SVC_TRANSPARENT;
			wsize      = '0;
			credits    = '0;
			next_tx    = '0;
			win_start  = '0;
			exp_rx     = '0;
			marks      = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function cred_t cap_window();
			return (int'(wsize) > EFF_CAP) ? cred_t'(EFF_CAP) : wsize;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_SERVICE_MODE) begin
				svc = svc_mode_t'(val[1:0]);
			end else if (idx == CFG_WINDOW_SIZE) begin
				wsize   = cred_t'(val);
				credits = cap_window();
			end
		endfunction

		function void note_event(in_mode_t m, seq_t sn, logic complete, logic ack);
			arq_result_t r;
			seq_t        new_start;
			int          span;
			int          slot;
			r        = '0;
			r.status = STAT_OK;
			case (m)
				MODE_SEND: begin
					if (svc == SVC_SEQUENCED) begin
						r.seq_out = next_tx;
						next_tx   = next_tx + seq_t'(1);
					end else if (svc == SVC_FLOW || svc == SVC_FLOW_ARQ) begin
						if (credits == '0) begin
							r.status = STAT_FULL;
						end else begin
							slot    = int'(next_tx) % SLOTS;
							credits = credits - cred_t'(1);
							if (marks[slot]) begin
								r.status = STAT_OVERWRITE;
							end
							marks[slot] = 1'b1;
							r.seq_out   = next_tx;
							next_tx     = next_tx + seq_t'(1);
						end
					end
				end
				MODE_DATA: begin
					if (complete && sn == exp_rx) begin
						exp_rx    = sn + seq_t'(1);
						r.deliver = 1'b1;
						if (svc == SVC_FLOW || svc == SVC_FLOW_ARQ) begin
							r.send_ack = 1'b1;
							r.seq_out  = sn;
						end
					end else begin
						r.status = STAT_DROPPED;
					end
				end
				MODE_FEEDBACK: begin
					if (ack) begin
						new_start = sn + seq_t'(1);
						span      = int'(seq_t'(new_start - win_start));
						if (span > SLOTS) begin
							span = SLOTS;
						end
						for (int i = 0; i < span; i++) begin
							slot = ((int'(win_start) + i) % SEQ_MOD) % SLOTS;
							if (marks[slot]) begin
								marks[slot] = 1'b0;
								if (credits < cap_window()) begin
									credits = credits + cred_t'(1);
								end
							end
						end
						win_start = new_start;
					end else begin
						r.status = STAT_NACK;
					end
				end
				default: begin
				end
			endcase
			r.credits = credits;
			r.base    = win_start;
			results_due.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			mismatches++;
			$display("result %0d: %s got %0d expected %0d", checked, what, got, want);
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] word);
			arq_result_t want;
			checked++;
			if (results_due.size() == 0) begin
				report("unexpected result, word", word, 0);
				return;
			end
			want = results_due.pop_front();
			if (word[2:0] != want.status)
				report("status", word[2:0], want.status);
			if (word[14:3] != want.seq_out)
				report("seq_out", word[14:3], want.seq_out);
			if (word[15] != want.deliver)
				report("deliver", word[15], want.deliver);
			if (word[16] != want.send_ack)
				report("send_ack", word[16], want.send_ack);
			if (word[21:17] != want.credits)
				report("credits_left", word[21:17], want.credits);
			if (word[33:22] != want.base)
				report("window_base", word[33:22], want.base);
		endtask
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;
	logic [IN_TUSER_W-1:0]   s_tuser   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;

	window_checker           sb;
	int                      send_idle   = 0;
	int                      recv_idle   = 25;
	int                      hold_req    = 0;
	int unsigned             cycle_count = 0;

	sliding_window_arq_tracker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	initial begin
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_event(in_mode_t m, seq_t sn, logic complete, logic ack);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({complete, sn});
		s_tuser  <= IN_TUSER_W'({ack, m});
		do @(posedge clk); while (!s_tready);
		sb.note_event(m, sn, complete, ack);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_register(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_random();
		in_mode_t m;
		seq_t     sn;
		logic     complete;
		logic     ack;
		int       pick;
		int       gap;
		pick     = $urandom_range(99);
		sn       = seq_t'($urandom);
		complete = 1'($urandom);
		ack      = 1'($urandom);
		if (pick < 45) begin
			m = MODE_SEND;
		end else if (pick < 70) begin
			m = MODE_DATA;
			if ($urandom_range(99) < 80) sn = sb.exp_rx;
			complete = ($urandom_range(99) < 85);
		end else if (pick < 93) begin
			m    = MODE_FEEDBACK;
			ack  = ($urandom_range(99) < 90);
			gap  = int'(seq_t'(sb.next_tx - sb.win_start));
			pick = $urandom_range(99);
			if (pick < 50 && gap <= SLOTS) begin
				sn = sb.win_start + seq_t'($urandom_range(gap)) - seq_t'(1);
			end else if (pick < 80) begin
				sn = sb.next_tx + seq_t'($urandom_range(6)) - seq_t'(3);
			end
		end else begin
			m = MODE_UNUSED;
		end
		send_event(m, sn, complete, ack);
	endtask

	task automatic run_directed();
		send_event(MODE_SEND, 12'd0, 1'b0, 1'b0);
		send_event(MODE_UNUSED, 12'hFFF, 1'b1, 1'b1);
		send_event(MODE_DATA, 12'd0, 1'b1, 1'b0);
		send_event(MODE_DATA, 12'd5, 1'b1, 1'b1);
		send_event(MODE_DATA, 12'd1, 1'b0, 1'b0);
		send_event(MODE_FEEDBACK, 12'hFFF, 1'b0, 1'b0);
		send_event(MODE_FEEDBACK, 12'hFFF, 1'b1, 1'b1);
		drain();
		write_reg(CFG_SERVICE_MODE, CFG_DATA_W'(SVC_SEQUENCED));
		send_event(MODE_SEND, 12'hFFF, 1'b1, 1'b1);
		send_event(MODE_SEND, 12'd0, 1'b0, 1'b0);
		drain();
		write_reg(CFG_SERVICE_MODE, CFG_DATA_W'(SVC_FLOW));
		write_reg(CFG_WINDOW_SIZE, 5'd0);
		send_event(MODE_SEND, 12'd0, 1'b0, 1'b0);
		drain();
		write_reg(CFG_WINDOW_SIZE, 5'd2);
		send_event(MODE_SEND, 12'd0, 1'b0, 1'b0);
		send_event(MODE_SEND, 12'd0, 1'b0, 1'b0);
		send_event(MODE_SEND, 12'd0, 1'b0, 1'b0);
		send_event(MODE_DATA, 12'd1, 1'b1, 1'b0);
		send_event(MODE_FEEDBACK, 12'd2, 1'b0, 1'b1);
		drain();
		write_reg(CFG_WINDOW_SIZE, 5'd2);
		write_reg(CFG_SERVICE_MODE, CFG_DATA_W'(SVC_FLOW_ARQ));
		send_event(MODE_FEEDBACK, 12'd3, 1'b1, 1'b1);
		send_event(MODE_FEEDBACK, 12'd2000, 1'b0, 1'b1);
		send_event(MODE_DATA, 12'hFFF, 1'b1, 1'b0);
		send_event(MODE_DATA, 12'd2, 1'b1, 1'b1);
		drain();
		write_reg(CFG_WINDOW_SIZE, 5'd31);
		send_event(MODE_SEND, 12'hFFF, 1'b1, 1'b1);
	endtask

	initial begin
		svc_mode_t phase_svc [6];
		int        phase_ws  [6];
		int        k;
		phase_svc = '{SVC_FLOW_ARQ, SVC_FLOW, SVC_FLOW_ARQ, SVC_SEQUENCED,
			SVC_TRANSPARENT, SVC_FLOW};
		phase_ws  = '{16, 31, 1, 12, 0, 5};
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int r = 0; r < 3; r++) begin
			send_idle = (r == 0) ? 20 : (r == 1) ? 53 : 0;
			recv_idle = (r == 0) ? 53 : (r == 1) ? 20 : 0;
			for (int p = 0; p < 6; p++) begin
				k = (p + 2 * r) % 6;
				drain();
				write_reg(CFG_SERVICE_MODE, CFG_DATA_W'(phase_svc[k]));
				write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(phase_ws[k]));
				if (r == 2 && p == 0) begin
					hold_req <= hold_req + 1;
				end
				repeat (PHASE_ITEMS) send_random();
			end
		end
		drain();
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
